@@ design/assert_macros.svh @@
// Assertion macros for the Playfair digraph encryptor.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ design/pf_pkg.sv @@
// Shared constants, types and helpers for the Playfair digraph encryptor.
// No dependencies.
`timescale 1ns / 1ps

package pf_pkg;

   localparam int LETTER_W          = 5;
   localparam int GRID_SIZE_DEFAULT = 5;
   localparam int CELL_COUNT        = 25;
   localparam int CELLS_PER_WORD    = 10;
   localparam int WIDE_W            = 50;
   localparam int BOTTOM_W          = 25;
   localparam int CSR_DATA_W        = 50;
   localparam int CSR_INDEX_W       = 2;

   localparam logic [LETTER_W-1:0] LETTER_I     = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J     = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_MAX   = 5'd25;
   localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;

   localparam logic OP_LETTER = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_UPPER  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_MIDDLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BOTTOM  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILLER      = 2'd3;

   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                padded;
   } pair_type;

   // J folds onto I.
   function automatic logic [LETTER_W-1:0] map_letter(input logic [LETTER_W-1:0] v);
      return (v == LETTER_J) ? LETTER_I : v;
   endfunction

endpackage

@@ design/pf_pair.sv @@
// Digraph former: holds the first letter of a pair and splits doubles.
// Depends on pf_pkg.
`timescale 1ns / 1ps

module pf_pair (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         op,
   input  logic [pf_pkg::LETTER_W-1:0]  letter,
   input  logic [pf_pkg::LETTER_W-1:0]  filler,
   output logic                         emit,
   output pf_pkg::pair_type             pair,
   output logic                         holding
);

   logic [pf_pkg::LETTER_W-1:0] held_ff, held_in;
   logic                        holding_ff, holding_in;
   logic [pf_pkg::LETTER_W-1:0] fill;
   logic [pf_pkg::LETTER_W-1:0] mapped;

   assign fill    = pf_pkg::map_letter(filler);
   assign mapped  = pf_pkg::map_letter(letter);
   assign holding = holding_ff;

   always_comb begin
      held_in     = held_ff;
      holding_in  = holding_ff;
      emit        = 1'b0;
      pair.first  = held_ff;
      pair.second = fill;
      pair.padded = 1'b1;
      case (op)
         pf_pkg::OP_FLUSH: begin
            // pad a lone held letter
            emit       = holding_ff;
            holding_in = 1'b0;
         end
         pf_pkg::OP_LETTER: begin
            if (letter <= pf_pkg::LETTER_MAX) begin
               if (!holding_ff) begin
                  held_in    = mapped;
                  holding_in = 1'b1;
               end else if (mapped == held_ff) begin
                  // split the double, keep the new letter held
                  emit    = 1'b1;
                  held_in = mapped;
               end else begin
                  emit        = 1'b1;
                  pair.second = mapped;
                  pair.padded = 1'b0;
                  holding_in  = 1'b0;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         holding_ff <= 1'b0;
      end else if (accept) begin
         held_ff    <= held_in;
         holding_ff <= holding_in;
      end
   end

endmodule

@@ design/pf_lookup.sv @@
// Key square lookup: locates both letters and applies the Playfair rules.
// Depends on pf_pkg.
`timescale 1ns / 1ps

module pf_lookup #(
   parameter int GRID_SIZE = pf_pkg::GRID_SIZE_DEFAULT
) (
   input  pf_pkg::pair_type              pair,
   input  logic [pf_pkg::WIDE_W-1:0]     square_upper,
   input  logic [pf_pkg::WIDE_W-1:0]     square_middle,
   input  logic [pf_pkg::BOTTOM_W-1:0]   square_bottom,
   output logic [pf_pkg::LETTER_W-1:0]   cipher_first,
   output logic [pf_pkg::LETTER_W-1:0]   cipher_second,
   output logic                          padded
);

   localparam int POS_W = $clog2(GRID_SIZE);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_SIZE - 1);

   typedef logic [pf_pkg::LETTER_W-1:0] grid_type [GRID_SIZE][GRID_SIZE];

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } pos_type;

   grid_type grid;
   pos_type  pos_a, pos_b;
   logic [POS_W-1:0] next_col_a, next_col_b, next_row_a, next_row_b;

   // last match in row-major order wins; no match sits at row 0, column 0
   function automatic pos_type locate(input grid_type g,
                                      input logic [pf_pkg::LETTER_W-1:0] v);
      pos_type p;
      p = '0;
      for (int r = 0; r < GRID_SIZE; r++) begin
         for (int c = 0; c < GRID_SIZE; c++) begin
            if (g[r][c] == v) begin
               p.row = POS_W'(r);
               p.col = POS_W'(c);
            end
         end
      end
      return p;
   endfunction

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
      return (p == LAST_POS) ? '0 : p + POS_W'(1);
   endfunction

   // unpack the key square; cells past the held ones read as zero
   always_comb begin
      int k;
      for (int r = 0; r < GRID_SIZE; r++) begin
         for (int c = 0; c < GRID_SIZE; c++) begin
            k = r * GRID_SIZE + c;
            if (k < pf_pkg::CELLS_PER_WORD) begin
               grid[r][c] = square_upper[pf_pkg::LETTER_W*k +: pf_pkg::LETTER_W];
            end else if (k < 2 * pf_pkg::CELLS_PER_WORD) begin
               grid[r][c] = square_middle[pf_pkg::LETTER_W*(k - pf_pkg::CELLS_PER_WORD)
                                          +: pf_pkg::LETTER_W];
            end else if (k < pf_pkg::CELL_COUNT) begin
               grid[r][c] = square_bottom[pf_pkg::LETTER_W*(k - 2 * pf_pkg::CELLS_PER_WORD)
                                          +: pf_pkg::LETTER_W];
            end else begin
               grid[r][c] = '0;
            end
         end
      end
   end

   assign pos_a      = locate(grid, pair.first);
   assign pos_b      = locate(grid, pair.second);
   assign next_col_a = next_pos(pos_a.col);
   assign next_col_b = next_pos(pos_b.col);
   assign next_row_a = next_pos(pos_a.row);
   assign next_row_b = next_pos(pos_b.row);
   assign padded     = pair.padded;

   always_comb begin
      if (pos_a.row == pos_b.row) begin
         cipher_first  = grid[pos_a.row][next_col_a];
         cipher_second = grid[pos_b.row][next_col_b];
      end else if (pos_a.col == pos_b.col) begin
         cipher_first  = grid[next_row_a][pos_a.col];
         cipher_second = grid[next_row_b][pos_b.col];
      end else begin
         // rectangle: own row, partner's column
         cipher_first  = grid[pos_a.row][pos_b.col];
         cipher_second = grid[pos_b.row][pos_a.col];
      end
   end

endmodule

@@ design/playfair_digraph_encrypt.sv @@
// Playfair digraph encryptor, top level: config registers and pipeline control.
// Depends on pf_pkg, pf_pair, pf_lookup and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one letter or flush beat per cycle, sustained, as long as the result
// side keeps up. A beat that completes a digraph reaches the rsp_ channel by
// way of the pairing register and then the result register: the held letter
// is matched against the new one as the beat is taken and the pair loads the
// pairing register, then the lookup stage, where parallel comparators find
// both letters in the key square, feeds the result register once it is free.
// The rate is set by that lookup stage, one pair per cycle when not stalled.
// Key square and filler must be written while the block is idle.
module playfair_digraph_encrypt #(
   parameter int GRID_SIZE = pf_pkg::GRID_SIZE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [pf_pkg::LETTER_W-1:0]     req_letter,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pf_pkg::LETTER_W-1:0]     rsp_cipher_first,
   output logic [pf_pkg::LETTER_W-1:0]     rsp_cipher_second,
   output logic                            rsp_padded,
   input  logic                            csr_write_enable,
   input  logic [pf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pf_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic [pf_pkg::WIDE_W-1:0]   upper_ff, middle_ff;
   logic [pf_pkg::BOTTOM_W-1:0] bottom_ff;
   logic [pf_pkg::LETTER_W-1:0] filler_ff;

   logic                 s1_valid_ff, s1_valid_in;
   pf_pkg::pair_type     s1_pair_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [pf_pkg::LETTER_W-1:0] rsp_first_ff, rsp_second_ff;
   logic                 rsp_padded_ff;

   logic                 req_accept, out_free, s1_move;
   logic                 emit, holding;
   pf_pkg::pair_type     pair;
   logic [pf_pkg::LETTER_W-1:0] lk_first, lk_second;
   logic                 lk_padded;
   logic                 flush_beat, first_beat, rsp_drain;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= '0;
         middle_ff <= '0;
         bottom_ff <= '0;
         filler_ff <= pf_pkg::FILLER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pf_pkg::CSR_ROWS_UPPER:  upper_ff  <= csr_write_data[pf_pkg::WIDE_W-1:0];
            pf_pkg::CSR_ROWS_MIDDLE: middle_ff <= csr_write_data[pf_pkg::WIDE_W-1:0];
            pf_pkg::CSR_ROW_BOTTOM:  bottom_ff <= csr_write_data[pf_pkg::BOTTOM_W-1:0];
            pf_pkg::CSR_FILLER:      filler_ff <= csr_write_data[pf_pkg::LETTER_W-1:0];
            default: begin
               filler_ff <= filler_ff;
            end
         endcase
      end
   end

   pf_pair u_pair (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .op      (req_op),
      .letter  (req_letter),
      .filler  (filler_ff),
      .emit    (emit),
      .pair    (pair),
      .holding (holding)
   );

   pf_lookup #(
      .GRID_SIZE (GRID_SIZE)
   ) u_lookup (
      .pair          (s1_pair_ff),
      .square_upper  (upper_ff),
      .square_middle (middle_ff),
      .square_bottom (bottom_ff),
      .cipher_first  (lk_first),
      .cipher_second (lk_second),
      .padded        (lk_padded)
   );

   always_comb begin
      // a beat that forms a pair loads the pairing register
      if (req_accept && emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         s1_pair_ff <= pair;
      end
      if (s1_move) begin
         rsp_first_ff  <= lk_first;
         rsp_second_ff <= lk_second;
         rsp_padded_ff <= lk_padded;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cipher_first  = rsp_first_ff;
   assign rsp_cipher_second = rsp_second_ff;
   assign rsp_padded        = rsp_padded_ff;

   assign flush_beat = req_accept && req_op == pf_pkg::OP_FLUSH;
   assign first_beat = req_accept && req_op == pf_pkg::OP_LETTER
                       && req_letter <= pf_pkg::LETTER_MAX && !holding;
   assign rsp_drain  = rsp_valid_ff && !rsp_stall && !s1_valid_ff;

   `ASSERT_NEXT(a_flush_drops_held, clock, reset, flush_beat, !holding, "flush left a letter held")
   `ASSERT_NEXT(a_first_letter_held, clock, reset, first_beat, holding, "first letter not held")
   `ASSERT_NEXT(a_blocked_pair_kept, clock, reset, req_stall, s1_valid_ff, "pending pair lost")
   `ASSERT_NEXT(a_result_drains, clock, reset, rsp_drain, !rsp_valid_ff, "result repeated")

endmodule

@@ tb/playfair_digraph_encrypt_test.sv @@
// Self-checking testbench for playfair_digraph_encrypt: directed table, then random phases.
// Depends on pf_pkg and the playfair_digraph_encrypt RTL; predicts digraphs on its own.
`timescale 1ns / 1ps

module playfair_digraph_encrypt_test;
   import pf_pkg::*;

   localparam int GRID          = GRID_SIZE_DEFAULT;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_LIMIT    = 2000;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 62;

   typedef struct {
      bit                    is_csr;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0] data;
      logic                  op;
      logic [LETTER_W-1:0]   letter;
      bit                    typed;
      bit                    has_pair;
      pair_type              pair;
   } stim_row_type;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic                   req_op            = OP_LETTER;
   logic [LETTER_W-1:0]    req_letter        = '0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic [LETTER_W-1:0]    rsp_cipher_first;
   logic [LETTER_W-1:0]    rsp_cipher_second;
   logic                   rsp_padded;
   logic                   csr_write_enable  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data    = '0;

   // predictor copy of the registers and the pairing state
   logic [WIDE_W-1:0]   key_upper;
   logic [WIDE_W-1:0]   key_middle;
   logic [BOTTOM_W-1:0] key_bottom;
   logic [LETTER_W-1:0] filler_reg;
   logic [LETTER_W-1:0] held_ltr;
   bit                  letter_held;

   pair_type            expected_pairs[$];
   stim_row_type        directed_rows[$];
   logic [LETTER_W-1:0] key_cells[CELL_COUNT];
   int                  mismatches  = 0;
   int                  idle_cycles = 0;
   bit                  stall_enable = 1'b1;
   bit                  gap_enable   = 1'b1;

   playfair_digraph_encrypt #(.GRID_SIZE(GRID)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_letter        (req_letter),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cipher_first  (rsp_cipher_first),
      .rsp_cipher_second (rsp_cipher_second),
      .rsp_padded        (rsp_padded),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   // ---------------- predictor ----------------

   function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] v);
      return (v == LETTER_J) ? LETTER_I : v;
   endfunction

   function automatic logic [LETTER_W-1:0] square_at(input int k);
      if (k < 10) return key_upper[5*k +: 5];
      if (k < 20) return key_middle[5*(k-10) +: 5];
      if (k < 25) return key_bottom[5*(k-20) +: 5];
      return '0;
   endfunction

   // last matching cell wins; a missing letter sits at the top left corner
   function automatic void locate_letter(input logic [LETTER_W-1:0] v,
                                         output int row, output int col);
      row = 0;
      col = 0;
      for (int r = 0; r < GRID; r++)
         for (int c = 0; c < GRID; c++)
            if (square_at(r*GRID + c) == v) begin
               row = r;
               col = c;
            end
   endfunction

   function automatic int wrap_next(input int p);
      return (p + 1 >= GRID) ? 0 : p + 1;
   endfunction

   function automatic pair_type encipher(input logic [LETTER_W-1:0] a,
                                         input logic [LETTER_W-1:0] b,
                                         input logic pad);
      int r1, c1, r2, c2;
      pair_type res;
      locate_letter(a, r1, c1);
      locate_letter(b, r2, c2);
      if (r1 == r2) begin
         res.first  = square_at(r1*GRID + wrap_next(c1));
         res.second = square_at(r2*GRID + wrap_next(c2));
      end else if (c1 == c2) begin
         res.first  = square_at(wrap_next(r1)*GRID + c1);
         res.second = square_at(wrap_next(r2)*GRID + c2);
      end else begin
         res.first  = square_at(r1*GRID + c2);
         res.second = square_at(r2*GRID + c1);
      end
      res.padded = pad;
      return res;
   endfunction

   function automatic bit next_digraph(input logic op, input logic [LETTER_W-1:0] letter,
                                       output pair_type res);
      logic [LETTER_W-1:0] fill;
      logic [LETTER_W-1:0] v;
      fill = fold_j(filler_reg);
      res  = '0;
      if (op == OP_FLUSH) begin
         if (!letter_held) return 1'b0;
         res = encipher(held_ltr, fill, 1'b1);
         letter_held = 1'b0;
         return 1'b1;
      end
      if (letter > LETTER_MAX) return 1'b0;
      v = fold_j(letter);
      if (!letter_held) begin
         held_ltr    = v;
         letter_held = 1'b1;
         return 1'b0;
      end
      if (v == held_ltr) begin
         // doubled letter: split with the filler, keep the new one held
         res = encipher(held_ltr, fill, 1'b1);
         return 1'b1;
      end
      res = encipher(held_ltr, v, 1'b0);
      letter_held = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_cells(input int first, input int count);
      logic [CSR_DATA_W-1:0] w;
      w = '0;
      for (int k = 0; k < count; k++) w[5*k +: 5] = key_cells[first + k];
      return w;
   endfunction

   // ---------------- stimulus helpers ----------------

   task automatic add_beat(input logic op, input logic [LETTER_W-1:0] letter,
                           input bit typed = 1'b0, input bit has = 1'b0,
                           input pair_type pair = '0);
      stim_row_type row;
      row = '{default: '0};
      row.op       = op;
      row.letter   = letter;
      row.typed    = typed;
      row.has_pair = has;
      row.pair     = pair;
      directed_rows.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] index,
                          input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.index  = index;
      row.data   = data;
      directed_rows.push_back(row);
   endtask

   // drain outstanding digraphs, then let the pipeline empty out
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_ROWS_UPPER:  key_upper  = data[WIDE_W-1:0];
         CSR_ROWS_MIDDLE: key_middle = data[WIDE_W-1:0];
         CSR_ROW_BOTTOM:  key_bottom = data[BOTTOM_W-1:0];
         CSR_FILLER:      filler_reg = data[LETTER_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // present one beat and hold it until accepted
   task automatic send_beat(input logic op, input logic [LETTER_W-1:0] letter,
                            input bit typed = 1'b0, input bit has = 1'b0,
                            input pair_type pair = '0);
      pair_type res;
      bit got;
      req_valid  <= 1'b1;
      req_op     <= op;
      req_letter <= letter;
      do @(posedge clock); while (req_stall);
      got = next_digraph(op, letter, res);
      if (typed) begin
         got = has;
         res = pair;
      end
      if (got) expected_pairs.push_back(res);
   endtask

   task automatic maybe_pause();
      int n;
      if (gap_enable && $urandom_range(0, 3) == 0) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      static int stall_left = 0;
      if (reset || !stall_enable) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected digraph %0d %0d padded %0d",
                        rsp_cipher_first, rsp_cipher_second, rsp_padded);
            mismatches++;
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_cipher_first !== want.first || rsp_cipher_second !== want.second ||
                rsp_padded !== want.padded) begin
               if (mismatches < 10)
                  $display("digraph mismatch: expected %0d %0d padded %0d, got %0d %0d padded %0d",
                           want.first, want.second, want.padded,
                           rsp_cipher_first, rsp_cipher_second, rsp_padded);
               mismatches++;
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      string               key;
      logic [LETTER_W-1:0] pool[$];
      logic [LETTER_W-1:0] last_ltr;
      logic [LETTER_W-1:0] tmp;
      logic [CSR_DATA_W-1:0] junk;
      int                  j;
      int                  pick;

      key_upper   = '0;
      key_middle  = '0;
      key_bottom  = '0;
      filler_reg  = FILLER_RESET;
      held_ltr    = '0;
      letter_held = 1'b0;

      // reset state: every cell is zero, so every digraph comes out as zeros
      add_beat(OP_FLUSH,  5'd0,  1, 0);
      add_beat(OP_LETTER, 5'd26, 1, 0);
      add_beat(OP_LETTER, 5'd31, 1, 0);
      add_beat(OP_LETTER, 5'd0,  1, 0);
      add_beat(OP_LETTER, 5'd25, 1, 1, '{5'd0, 5'd0, 1'b0});
      add_beat(OP_LETTER, LETTER_J, 1, 0);
      add_beat(OP_LETTER, LETTER_I, 1, 1, '{5'd0, 5'd0, 1'b1});
      add_beat(OP_FLUSH,  5'd0,  1, 1, '{5'd0, 5'd0, 1'b1});
      add_beat(OP_LETTER, 5'd0,  1, 0);
      add_beat(OP_FLUSH,  5'd31, 1, 1, '{5'd0, 5'd0, 1'b1});

      // a proper key square: same row, same column, rectangle, J folding, doubles
      key = "PLAYFIREXMBCDGHKNOQSTUVWZ";
      for (int k = 0; k < CELL_COUNT; k++) key_cells[k] = 5'(key[k] - "A");
      add_csr(CSR_ROWS_UPPER,  pack_cells(0, 10));
      add_csr(CSR_ROWS_MIDDLE, pack_cells(10, 10));
      add_csr(CSR_ROW_BOTTOM,  pack_cells(20, 5));
      add_beat(OP_LETTER, 5'd15);
      add_beat(OP_LETTER, 5'd11);
      add_beat(OP_LETTER, 5'd15);
      add_beat(OP_LETTER, 5'd1);
      add_beat(OP_LETTER, 5'd0);
      add_beat(OP_LETTER, 5'd25);
      add_beat(OP_LETTER, LETTER_J);
      add_beat(OP_LETTER, 5'd24);
      add_beat(OP_LETTER, 5'd25);
      add_beat(OP_LETTER, 5'd25);
      add_beat(OP_FLUSH,  5'd0);
      // filler J folds onto I
      add_csr(CSR_FILLER, CSR_DATA_W'(LETTER_J));
      add_beat(OP_LETTER, LETTER_I);
      add_beat(OP_FLUSH,  5'd0);
      // filler outside the alphabet, cells duplicated and above the alphabet
      add_csr(CSR_FILLER, 50'd31);
      add_csr(CSR_ROWS_UPPER,  {WIDE_W{1'b1}});
      add_csr(CSR_ROWS_MIDDLE, '0);
      add_csr(CSR_ROW_BOTTOM,  {CSR_DATA_W{1'b1}});
      add_beat(OP_LETTER, 5'd0);
      add_beat(OP_FLUSH,  5'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle();
            write_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_beat(directed_rows[i].op, directed_rows[i].letter, directed_rows[i].typed,
                      directed_rows[i].has_pair, directed_rows[i].pair);
            maybe_pause();
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         stall_enable <= (ph % 3 != 2);
         gap_enable    = (ph % 3 != 2);
         case (ph)
            0: begin
               write_reg(CSR_ROWS_UPPER,  '0);
               write_reg(CSR_ROWS_MIDDLE, '0);
               write_reg(CSR_ROW_BOTTOM,  '0);
               write_reg(CSR_FILLER,      '0);
            end
            1: begin
               write_reg(CSR_ROWS_UPPER,  {CSR_DATA_W{1'b1}});
               write_reg(CSR_ROWS_MIDDLE, {CSR_DATA_W{1'b1}});
               write_reg(CSR_ROW_BOTTOM,  {CSR_DATA_W{1'b1}});
               write_reg(CSR_FILLER,      50'd25);
            end
            2: begin
               write_reg(CSR_ROWS_UPPER,  CSR_DATA_W'({$urandom, $urandom}));
               write_reg(CSR_ROWS_MIDDLE, CSR_DATA_W'({$urandom, $urandom}));
               write_reg(CSR_ROW_BOTTOM,  CSR_DATA_W'({$urandom, $urandom}));
               write_reg(CSR_FILLER,      CSR_DATA_W'({$urandom, $urandom}));
            end
            default: begin
               // shuffled alphabet without J, the normal keyed square
               pool.delete();
               for (int l = 0; l <= LETTER_MAX; l++)
                  if (l != LETTER_J) pool.push_back(5'(l));
               for (int k = CELL_COUNT - 1; k > 0; k--) begin
                  j       = $urandom_range(0, k);
                  tmp     = pool[k];
                  pool[k] = pool[j];
                  pool[j] = tmp;
               end
               for (int k = 0; k < CELL_COUNT; k++) key_cells[k] = pool[k];
               // junk above the bottom row's cells, clear where the cells go
               junk = CSR_DATA_W'({$urandom, $urandom});
               junk[BOTTOM_W-1:0] = '0;
               write_reg(CSR_ROWS_UPPER,  pack_cells(0, 10));
               write_reg(CSR_ROWS_MIDDLE, pack_cells(10, 10));
               write_reg(CSR_ROW_BOTTOM,
                         ($urandom_range(0, 1) != 0) ? (junk | pack_cells(20, 5))
                                                     : pack_cells(20, 5));
               junk = CSR_DATA_W'({$urandom, $urandom});
               junk[4:0] = (ph == 3) ? LETTER_J : 5'($urandom_range(0, LETTER_MAX));
               if ($urandom_range(0, 1) == 0) junk[CSR_DATA_W-1:5] = '0;
               write_reg(CSR_FILLER, junk);
            end
         endcase

         last_ltr = 5'($urandom_range(0, LETTER_MAX));
         for (int n = 0; n < PHASE_BEATS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_beat(OP_FLUSH, 5'($urandom_range(0, 31)));
            end else begin
               if (pick < 13)
                  tmp = 5'($urandom_range(LETTER_MAX + 1, 31));
               else if (pick < 33)
                  // double up, sometimes through the J/I fold
                  tmp = (last_ltr == LETTER_I && $urandom_range(0, 1) != 0) ? LETTER_J
                                                                            : last_ltr;
               else if (pick < 43)
                  tmp = LETTER_J;
               else
                  tmp = 5'($urandom_range(0, LETTER_MAX));
               send_beat(OP_LETTER, tmp);
               if (tmp <= LETTER_MAX) last_ltr = fold_j(tmp);
            end
            maybe_pause();
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_pairs.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ playfair_digraph_encrypt.f @@
+incdir+design
design/pf_pkg.sv
design/pf_pair.sv
design/pf_lookup.sv
design/playfair_digraph_encrypt.sv
tb/playfair_digraph_encrypt_test.sv
